### rtl/cau_pkg.sv
// cau_pkg: shared types, widths and opcode codes for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DataWidth  = 32;
    localparam int FracBits   = 16;
    localparam int ProdWidth  = 2 * DataWidth;          // one signed product
    localparam int SumWidth   = ProdWidth + 1;          // sum of two products
    localparam int NumWidth   = SumWidth + FracBits;    // scaled dividend magnitude
    localparam int DivSteps   = NumWidth;               // one quotient bit per stage
    localparam int InWidth    = 4 * DataWidth;
    localparam int InBytes    = (InWidth + 7) / 8;
    localparam int OutWidth   = 2 * DataWidth;
    localparam int OutBytes   = (OutWidth + 7) / 8;

    localparam logic [1:0] OpAdd = 2'd0;
    localparam logic [1:0] OpSub = 2'd1;
    localparam logic [1:0] OpMul = 2'd2;
    localparam logic [1:0] OpDiv = 2'd3;

    typedef logic signed [DataWidth-1:0] data_t;
    typedef logic signed [SumWidth-1:0]  sum_t;

    typedef struct packed {
        logic [1:0] opcode;
        data_t      a_re;
        data_t      a_im;
        data_t      b_re;
        data_t      b_im;
    } operand_t;

    // sums of products after the multiply stages
    typedef struct packed {
        logic [1:0] opcode;
        sum_t       re;       // add/sub: exact value; mul/div: numerator
        sum_t       im;
        sum_t       den;      // |b|^2, divide only
    } product_t;

    // saturate a wide signed value to the data width
    function automatic data_t sat_wide(input logic signed [NumWidth+1:0] x,
                                       output logic ovf);
        logic signed [NumWidth+1:0] lim_hi;
        logic signed [NumWidth+1:0] lim_lo;
        lim_hi = (NumWidth+2)'((64'sd1 <<< (DataWidth - 1)) - 64'sd1);
        lim_lo = -lim_hi - (NumWidth+2)'(1);
        if (x > lim_hi) begin
            ovf = 1'b1;
            return data_t'(lim_hi);
        end else if (x < lim_lo) begin
            ovf = 1'b1;
            return data_t'(lim_lo);
        end
        ovf = 1'b0;
        return data_t'(x);
    endfunction

endpackage

### rtl/cau_mult.sv
// cau_mult: two-stage multiply and sum of the cross products
// depends on cau_pkg
module cau_mult (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::operand_t in_op,
    output logic              out_valid,
    output cau_pkg::product_t out_prod
);
    import cau_pkg::*;

    typedef logic signed [ProdWidth-1:0] prod_t;

    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;
    prod_t      p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    data_t      a_re_reg, a_im_reg;
    prod_t      p_rr_next, p_ii_next, p_ri_next, p_ir_next, p_bb_next, p_cc_next;
    logic       s2_valid_reg;
    product_t   s2_prod_reg;
    product_t   s2_prod_next;

    // stage one: the six products
    always_comb begin
        p_rr_next = in_op.a_re * in_op.b_re;
        p_ii_next = in_op.a_im * in_op.b_im;
        p_ri_next = in_op.a_re * in_op.b_im;
        p_ir_next = in_op.a_im * in_op.b_re;
        p_bb_next = in_op.b_re * in_op.b_re;
        p_cc_next = in_op.b_im * in_op.b_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    // add/sub operands ride along in the product registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg <= in_op.opcode;
            a_re_reg  <= in_op.a_re;
            a_im_reg  <= in_op.a_im;
            if (in_op.opcode == OpAdd || in_op.opcode == OpSub) begin
                p_rr_reg <= prod_t'(in_op.b_re);
                p_ii_reg <= prod_t'(in_op.b_im);
            end else begin
                p_rr_reg <= p_rr_next;
                p_ii_reg <= p_ii_next;
            end
            p_ri_reg <= p_ri_next;
            p_ir_reg <= p_ir_next;
            p_bb_reg <= p_bb_next;
            p_cc_reg <= p_cc_next;
        end
    end

    // stage two: combine products
    always_comb begin
        s2_prod_next.opcode = s1_op_reg;
        s2_prod_next.den    = sum_t'(p_bb_reg) + sum_t'(p_cc_reg);
        case (s1_op_reg)
            OpAdd: begin
                s2_prod_next.re = sum_t'(a_re_reg) + sum_t'(p_rr_reg);
                s2_prod_next.im = sum_t'(a_im_reg) + sum_t'(p_ii_reg);
            end
            OpSub: begin
                s2_prod_next.re = sum_t'(a_re_reg) - sum_t'(p_rr_reg);
                s2_prod_next.im = sum_t'(a_im_reg) - sum_t'(p_ii_reg);
            end
            OpMul: begin
                s2_prod_next.re = sum_t'(p_rr_reg) - sum_t'(p_ii_reg);
                s2_prod_next.im = sum_t'(p_ri_reg) + sum_t'(p_ir_reg);
            end
            default: begin
                s2_prod_next.re = sum_t'(p_rr_reg) + sum_t'(p_ii_reg);
                s2_prod_next.im = sum_t'(p_ir_reg) - sum_t'(p_ri_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_prod_reg <= s2_prod_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_prod  = s2_prod_reg;

endmodule

### rtl/cau_div.sv
// cau_div: pipelined restoring divider for both quotient parts, one bit per stage
// depends on cau_pkg
module cau_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::product_t in_prod,
    output logic              out_valid,
    output cau_pkg::product_t out_prod,     // passthrough of the entry values
    output logic [cau_pkg::NumWidth-1:0] out_q_re,
    output logic [cau_pkg::NumWidth-1:0] out_q_im
);
    import cau_pkg::*;

    typedef logic [NumWidth-1:0] num_t;
    typedef logic [SumWidth-1:0] den_t;
    typedef logic [SumWidth:0]   rem_t;

    logic     valid_reg [DivSteps+1];
    product_t prod_reg  [DivSteps+1];
    num_t     nre_reg   [DivSteps+1];    // dividend shifts out, quotient shifts in
    num_t     nim_reg   [DivSteps+1];
    rem_t     rre_reg   [DivSteps+1];
    rem_t     rim_reg   [DivSteps+1];

    num_t mag_re, mag_im;
    num_t half_den;

    // magnitude scaled by 2^frac, plus half the divisor for rounding
    always_comb begin
        half_den = num_t'(den_t'(in_prod.den) >> 1);
        mag_re = num_t'(in_prod.re[SumWidth-1] ? -in_prod.re : in_prod.re);
        mag_im = num_t'(in_prod.im[SumWidth-1] ? -in_prod.im : in_prod.im);
        mag_re = (mag_re << FracBits) + half_den;
        mag_im = (mag_im << FracBits) + half_den;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= in_prod;
            nre_reg[0]  <= mag_re;
            nim_reg[0]  <= mag_im;
            rre_reg[0]  <= '0;
            rim_reg[0]  <= '0;
        end
    end

    // one restoring step per register stage
    for (genvar i = 0; i < DivSteps; i++) begin : g_step
        rem_t tre, tim, dre, dim;
        rem_t dd;
        always_comb begin
            dd  = rem_t'(den_t'(prod_reg[i].den));
            tre = {rre_reg[i][SumWidth-1:0], nre_reg[i][NumWidth-1]};
            tim = {rim_reg[i][SumWidth-1:0], nim_reg[i][NumWidth-1]};
            dre = tre - dd;
            dim = tim - dd;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[i+1] <= prod_reg[i];
                rre_reg[i+1]  <= (tre >= dd) ? dre : tre;
                rim_reg[i+1]  <= (tim >= dd) ? dim : tim;
                nre_reg[i+1]  <= {nre_reg[i][NumWidth-2:0], tre >= dd};
                nim_reg[i+1]  <= {nim_reg[i][NumWidth-2:0], tim >= dd};
            end
        end
    end

    assign out_valid = valid_reg[DivSteps];
    assign out_prod  = prod_reg[DivSteps];
    assign out_q_re  = nre_reg[DivSteps];
    assign out_q_im  = nim_reg[DivSteps];

endmodule

### rtl/complex_arithmetic_unit_core.sv
// complex_arithmetic_unit_core: top level, round/saturate stage and output register
// depends on cau_pkg, cau_mult, cau_div
//
// Complex add, subtract, multiply and divide on signed Q16.16 operands. One
// beat is accepted per cycle whatever the opcode while the pipeline is not
// stalled; every result passes through two multiply stages, the divider's
// entry register, 81 divider stages (one quotient bit each over an 81-bit
// scaled dividend) and the output register. All operations share the one
// pipeline, so results keep input order. A master-side stall freezes the whole
// pipeline; s_axis_tready follows m_axis_tready or an empty output register.
module complex_arithmetic_unit_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_re, a_im, b_re, b_im from bit 0 up
    input  logic [8*cau_pkg::InBytes-1:0]    s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,   // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [8*cau_pkg::OutBytes-1:0]   m_axis_tdata,   // res_re, res_im
    output logic [1:0]                       m_axis_tuser    // overflow, divide_by_zero
);
    import cau_pkg::*;

    localparam int DW = DataWidth;
    typedef logic signed [NumWidth+1:0] wide_t;

    logic     en;
    operand_t in_op;
    logic     mv, dv;
    product_t mprod, dprod;
    logic [NumWidth-1:0] q_re, q_im;

    logic     out_valid_reg;
    data_t    re_reg, im_reg, re_next, im_next;
    logic     ovf_reg, dz_reg, ovf_next, dz_next;
    logic     o1, o2;
    wide_t    vre, vim;

    // whole pipeline advances unless the output register is stuck
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign in_op.opcode = s_axis_tuser;
    assign in_op.a_re   = s_axis_tdata[0*DW +: DW];
    assign in_op.a_im   = s_axis_tdata[1*DW +: DW];
    assign in_op.b_re   = s_axis_tdata[2*DW +: DW];
    assign in_op.b_im   = s_axis_tdata[3*DW +: DW];

    cau_mult u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_op    (in_op),
        .out_valid(mv),
        .out_prod (mprod)
    );

    cau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (mv),
        .in_prod  (mprod),
        .out_valid(dv),
        .out_prod (dprod),
        .out_q_re (q_re),
        .out_q_im (q_im)
    );

    // pick the value per opcode, round and saturate
    always_comb begin
        dz_next = 1'b0;
        case (dprod.opcode)
            OpAdd, OpSub: begin
                vre = wide_t'(dprod.re);
                vim = wide_t'(dprod.im);
            end
            OpMul: begin
                vre = (wide_t'(dprod.re) + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits;
                vim = (wide_t'(dprod.im) + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits;
            end
            default: begin
                vre = dprod.re[SumWidth-1] ? -wide_t'({2'b00, q_re}) : wide_t'({2'b00, q_re});
                vim = dprod.im[SumWidth-1] ? -wide_t'({2'b00, q_im}) : wide_t'({2'b00, q_im});
                if (dprod.den == '0) begin
                    dz_next = 1'b1;
                    vre = '0;
                    vim = '0;
                end
            end
        endcase
        re_next  = sat_wide(vre, o1);
        im_next  = sat_wide(vim, o2);
        ovf_next = o1 | o2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {im_reg, re_reg};
    assign m_axis_tuser  = {dz_reg, ovf_reg};

    // a divide-by-zero beat carries zero data and no overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && dz_reg) |-> (re_reg == '0 && im_reg == '0 && !ovf_reg))
        else $error("divide by zero result not cleared");

    // held result stays put while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(re_reg)))
        else $error("stalled result changed");

    // input is refused only when output is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("pipeline stalled without back pressure");

endmodule

### tb/complex_arithmetic_unit_core_tb.sv
// complex_arithmetic_unit_core_tb: self-checking bench for the complex add/sub/mul/div core
// depends on cau_pkg and complex_arithmetic_unit_core; directed table, then random beats
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_tb;
    import cau_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 200;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [1:0] op;
        data_t      a_re;
        data_t      a_im;
        data_t      b_re;
        data_t      b_im;
        bit         fixed;     // expectation typed in below
        data_t      e_re;
        data_t      e_im;
        logic       e_ovf;
        logic       e_dz;
    } row_t;

    typedef struct {
        data_t re;
        data_t im;
        logic  ovf;
        logic  dz;
    } cplx_result_t;

    localparam data_t DMax = 32'sh7fffffff;
    localparam data_t DMin = 32'sh80000000;
    localparam data_t One  = 32'sh00010000;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [8*InBytes-1:0]        s_axis_tdata;   // a_re, a_im, b_re, b_im
    logic [1:0]                  s_axis_tuser;   // opcode
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [8*OutBytes-1:0]       m_axis_tdata;   // res_re, res_im
    logic [1:0]                  m_axis_tuser;   // overflow, divide_by_zero

    cplx_result_t pending_results[$];
    cplx_result_t next_expect;
    bit           next_fixed;
    int           error_count;
    int           idle_cycles;

    complex_arithmetic_unit_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // clamp a wide value to the data width
    function automatic data_t clamp_q(input wide_t x, inout logic ovf);
        if (x > wide_t'(DMax)) begin
            ovf = 1'b1;
            return DMax;
        end
        if (x < wide_t'(DMin)) begin
            ovf = 1'b1;
            return DMin;
        end
        return data_t'(x);
    endfunction

    // scaled quotient, rounded half away from zero
    function automatic wide_t scaled_quot(input wide_t num, input wide_t den);
        bit    neg;
        wide_t mag;
        wide_t q;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = ((mag <<< FracBits) + (den >>> 1)) / den;
        return neg ? -q : q;
    endfunction

    // expected result of one operand beat
    function automatic cplx_result_t complex_result(input logic [1:0] op, input data_t ar,
                                                    input data_t ai, input data_t br,
                                                    input data_t bi);
        cplx_result_t r;
        wide_t        war, wai, wbr, wbi, re, im, den, half;
        war  = ar;
        wai  = ai;
        wbr  = br;
        wbi  = bi;
        half = wide_t'(1) <<< (FracBits - 1);
        r.ovf = 1'b0;
        r.dz  = 1'b0;
        re = 0;
        im = 0;
        case (op)
            OpAdd: begin
                re = war + wbr;
                im = wai + wbi;
            end
            OpSub: begin
                re = war - wbr;
                im = wai - wbi;
            end
            OpMul: begin
                re = (war * wbr - wai * wbi + half) >>> FracBits;
                im = (war * wbi + wai * wbr + half) >>> FracBits;
            end
            default: begin
                den = wbr * wbr + wbi * wbi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = scaled_quot(war * wbr + wai * wbi, den);
                    im = scaled_quot(wai * wbr - war * wbi, den);
                end
            end
        endcase
        r.re = clamp_q(re, r.ovf);
        r.im = clamp_q(im, r.ovf);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // random operand part: full range, small values, extremes
    function automatic data_t rand_part();
        case ($urandom_range(0, 9))
            0:       return DMax;
            1:       return DMin;
            2:       return '0;
            3, 4, 5: return data_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            default: return data_t'($urandom());
        endcase
    endfunction

    // beat capture, result check and watchdog
    always @(posedge aclk) begin
        cplx_result_t want;
        bit           moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                if (next_fixed)
                    pending_results.push_back(next_expect);
                else
                    pending_results.push_back(complex_result(s_axis_tuser,
                        s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tdata[95:64], s_axis_tdata[127:96]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_axis_tdata[31:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.re)
                        report_mismatch("res_re", m_axis_tdata[31:0], want.re);
                    if (m_axis_tdata[63:32] !== want.im)
                        report_mismatch("res_im", m_axis_tdata[63:32], want.im);
                    if (m_axis_tuser[0] !== want.ovf)
                        report_mismatch("overflow", 32'(m_axis_tuser[0]), 32'(want.ovf));
                    if (m_axis_tuser[1] !== want.dz)
                        report_mismatch("divide_by_zero", 32'(m_axis_tuser[1]),
                                        32'(want.dz));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side back-pressure, with calm stretches
    initial begin
        int calm;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            calm = ($urandom_range(0, 5) == 0);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, calm ? 120 : 8)) @(negedge aclk);
            if (!calm) begin
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3))
                    @(negedge aclk);
            end
        end
    end

    // drive one operand beat, gap first, and hold until accepted
    task automatic send_beat(input row_t r);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 15) == 0)
              ? $urandom_range(8, 40) : $urandom_range(1, 3)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        next_fixed          = r.fixed;
        next_expect.re      = r.e_re;
        next_expect.im      = r.e_im;
        next_expect.ovf     = r.e_ovf;
        next_expect.dz      = r.e_dz;
        s_axis_tvalid      <= 1'b1;
        s_axis_tuser       <= r.op;
        s_axis_tdata       <= {r.b_im, r.b_re, r.a_im, r.a_re};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge aclk);
    endtask

    // stimulus
    initial begin
        row_t directed[$];
        row_t r;
        int   waited;
        error_count   = 0;
        idle_cycles   = 0;
        next_fixed    = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OpAdd;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes, every operation, saturation and zero divisor
        directed = '{
            '{OpAdd, 0, 0, 0, 0, 1, 0, 0, 0, 0},
            '{OpAdd, DMax, DMin, DMax, DMin, 1, DMax, DMin, 1, 0},
            '{OpAdd, DMax, DMin, DMin, DMax, 1, -1, -1, 0, 0},
            '{OpSub, DMin, DMax, DMax, DMin, 1, DMin, DMax, 1, 0},
            '{OpSub, DMax, DMax, DMax, DMax, 1, 0, 0, 0, 0},
            '{OpMul, DMin, 0, DMin, 0, 1, DMax, 0, 1, 0},
            '{OpMul, One, 0, One, 0, 1, One, 0, 0, 0},
            '{OpMul, 0, One, 0, One, 1, -One, 0, 0, 0},
            '{OpMul, DMin, DMin, DMin, DMin, 1, 0, DMax, 1, 0},
            '{OpDiv, DMax, DMin, 0, 0, 1, 0, 0, 0, 1},
            '{OpDiv, 0, 0, 0, 0, 1, 0, 0, 0, 1},
            '{OpDiv, One, 0, One, 0, 1, One, 0, 0, 0},
            '{OpDiv, DMax, DMax, 1, 0, 1, DMax, DMax, 1, 0},
            '{OpDiv, DMin, DMax, 0, 1, 1, DMax, DMax, 1, 0},
            '{OpMul, DMax, DMax, DMax, DMin, 0, 0, 0, 0, 0},
            '{OpMul, 1, 1, 32'sh8000, 0, 0, 0, 0, 0, 0},
            '{OpMul, -1, 0, 32'sh8000, 0, 0, 0, 0, 0, 0},
            '{OpDiv, DMin, DMin, DMin, DMin, 0, 0, 0, 0, 0},
            '{OpDiv, DMax, DMin, DMax, DMin, 0, 0, 0, 0, 0},
            '{OpDiv, 1, -1, 3, 0, 0, 0, 0, 0, 0},
            '{OpDiv, One, One, -3, 7, 0, 0, 0, 0, 0},
            '{OpSub, 0, DMin, 1, 1, 0, 0, 0, 0, 0}
        };
        foreach (directed[i]) send_beat(directed[i]);

        // random operand beats
        repeat (800) begin
            r.op    = 2'($urandom_range(0, 3));
            r.a_re  = rand_part();
            r.a_im  = rand_part();
            r.b_re  = rand_part();
            r.b_im  = rand_part();
            r.fixed = 1'b0;
            if (r.op == OpDiv && $urandom_range(0, 15) == 0) begin
                r.b_re = '0;
                r.b_im = '0;
            end
            send_beat(r);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DrainCycles) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 32'(pending_results.size()), '0);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
